### design/qrrs_pkg.sv
// Shared types and codes for the quadratic real-root solver.
// No dependencies; imported by qrrs_front and the top level.
package qrrs_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_TWO    = 2'd0,  // two distinct real roots
    ST_DOUBLE = 2'd1,  // one double root
    ST_NONE   = 2'd2,  // discriminant negative
    ST_AZERO  = 2'd3   // leading coefficient zero
  } status_t;

endpackage

### design/qrrs_front.sv
// Front end: coefficient sign/magnitude split, products, discriminant.
// Three register stages. Depends on qrrs_pkg.
module qrrs_front import qrrs_pkg::*; #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [W-1:0]      coef_a_i,
  input  logic [W-1:0]      coef_b_i,
  input  logic [W-1:0]      coef_c_i,
  output logic              valid_o,
  output logic [2*W+1:0]    d_o,
  output status_t           status_o,
  output logic              sa_o,
  output logic              sb_o,
  output logic [W-1:0]      am_o,
  output logic [W-1:0]      bm_o
);

  localparam int DW = 2 * W + 2;

  // stage 1: magnitudes
  logic         v1_r, sa1_r, sb1_r, sc1_r;
  logic [W-1:0] am1_r, bm1_r, cm1_r;
  // stage 2: products
  logic           v2_r, sa2_r, sb2_r, add2_r, az2_r;
  logic [W-1:0]   am2_r, bm2_r;
  logic [2*W-1:0] b2_r, ac_r;
  // stage 3: discriminant
  logic          v3_r, sa3_r, sb3_r;
  logic [W-1:0]  am3_r, bm3_r;
  logic [DW-1:0] d3_r, d_nxt;
  status_t       st3_r, st_nxt;

  logic [DW-1:0] b2_e, ac4_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa1_r  <= coef_a_i[W-1];
      sb1_r  <= coef_b_i[W-1];
      sc1_r  <= coef_c_i[W-1];
      am1_r  <= coef_a_i[W-1] ? (~coef_a_i + 1'b1) : coef_a_i;
      bm1_r  <= coef_b_i[W-1] ? (~coef_b_i + 1'b1) : coef_b_i;
      cm1_r  <= coef_c_i[W-1] ? (~coef_c_i + 1'b1) : coef_c_i;

      b2_r   <= bm1_r * bm1_r;
      ac_r   <= am1_r * cm1_r;
      sa2_r  <= sa1_r;
      sb2_r  <= sb1_r;
      am2_r  <= am1_r;
      bm2_r  <= bm1_r;
      add2_r <= (cm1_r != '0) && (sa1_r != sc1_r);
      az2_r  <= (am1_r == '0);

      d3_r   <= d_nxt;
      st3_r  <= st_nxt;
      sa3_r  <= sa2_r;
      sb3_r  <= sb2_r;
      am3_r  <= am2_r;
      bm3_r  <= bm2_r;
    end
  end

  // ac sign differs: D = b^2 + 4|ac|, else D = b^2 - 4|ac|
  always_comb begin
    b2_e  = {2'b00, b2_r};
    ac4_e = {ac_r, 2'b00};
    st_nxt = ST_TWO;
    if (add2_r) begin
      d_nxt = b2_e + ac4_e;
    end else begin
      d_nxt = b2_e - ac4_e;
      if (b2_e < ac4_e) begin
        st_nxt = ST_NONE;
      end
    end
    if (az2_r) begin
      st_nxt = ST_AZERO;
    end
  end

  assign valid_o  = v3_r;
  assign d_o      = d3_r;
  assign status_o = st3_r;
  assign sa_o     = sa3_r;
  assign sb_o     = sb3_r;
  assign am_o     = am3_r;
  assign bm_o     = bm3_r;

endmodule

### design/qrrs_sqrt_cell.sv
// One digit cell of the pipelined integer square root: two radicand bits in,
// one root bit out per cell. No package dependency.
module qrrs_sqrt_cell #(
  parameter int RAD_W  = 66,
  parameter int ROOT_W = 33,
  parameter int SIDE_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [ROOT_W:0]   rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [RAD_W-1:0]  rad_o,
  output logic [ROOT_W:0]   rem_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_r;
  logic [RAD_W-1:0]  rad_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [SIDE_W-1:0] side_r;

  logic [ROOT_W+2:0] rem_s, trial, diff;
  logic              ge;

  always_comb begin
    rem_s = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial = {1'b0, root_i, 2'b01};
    ge    = (rem_s >= trial);
    diff  = ge ? (rem_s - trial) : rem_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[RAD_W-3:0], 2'b00};
      rem_r  <= diff[ROOT_W:0];
      root_r <= {root_i[ROOT_W-2:0], ge};
      side_r <= side_i;
    end
  end

  assign valid_o = valid_r;
  assign rad_o   = rad_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign side_o  = side_r;

endmodule

### design/qrrs_div_cell.sv
// One bit cell of the pipelined restoring divider, two lanes sharing a divisor.
// No package dependency.
module qrrs_div_cell #(
  parameter int NUM_W  = 51,
  parameter int DIV_W  = 33,
  parameter int SIDE_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  logic [DIV_W-1:0]  div_i,
  input  logic [NUM_W-1:0]  num_a_i,
  input  logic [NUM_W-1:0]  num_b_i,
  input  logic [DIV_W-1:0]  rem_a_i,
  input  logic [DIV_W-1:0]  rem_b_i,
  input  logic [NUM_W-1:0]  quot_a_i,
  input  logic [NUM_W-1:0]  quot_b_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [DIV_W-1:0]  div_o,
  output logic [NUM_W-1:0]  num_a_o,
  output logic [NUM_W-1:0]  num_b_o,
  output logic [DIV_W-1:0]  rem_a_o,
  output logic [DIV_W-1:0]  rem_b_o,
  output logic [NUM_W-1:0]  quot_a_o,
  output logic [NUM_W-1:0]  quot_b_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_r;
  logic [DIV_W-1:0]  div_r, rem_a_r, rem_b_r;
  logic [NUM_W-1:0]  num_a_r, num_b_r, quot_a_r, quot_b_r;
  logic [SIDE_W-1:0] side_r;

  logic [DIV_W:0] ra_s, rb_s, ra_d, rb_d, dv_e;
  logic           ge_a, ge_b;

  always_comb begin
    dv_e = {1'b0, div_i};
    ra_s = {rem_a_i, num_a_i[NUM_W-1]};
    rb_s = {rem_b_i, num_b_i[NUM_W-1]};
    ge_a = (ra_s >= dv_e);
    ge_b = (rb_s >= dv_e);
    ra_d = ge_a ? (ra_s - dv_e) : ra_s;
    rb_d = ge_b ? (rb_s - dv_e) : rb_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r    <= div_i;
      num_a_r  <= {num_a_i[NUM_W-2:0], 1'b0};
      num_b_r  <= {num_b_i[NUM_W-2:0], 1'b0};
      rem_a_r  <= ra_d[DIV_W-1:0];
      rem_b_r  <= rb_d[DIV_W-1:0];
      quot_a_r <= {quot_a_i[NUM_W-2:0], ge_a};
      quot_b_r <= {quot_b_i[NUM_W-2:0], ge_b};
      side_r   <= side_i;
    end
  end

  assign valid_o  = valid_r;
  assign div_o    = div_r;
  assign num_a_o  = num_a_r;
  assign num_b_o  = num_b_r;
  assign rem_a_o  = rem_a_r;
  assign rem_b_o  = rem_b_r;
  assign quot_a_o = quot_a_r;
  assign quot_b_o = quot_b_r;
  assign side_o   = side_r;

endmodule

### design/quadratic_real_root_solver.sv
// Quadratic real-root solver: roots of a*x^2+b*x+c in signed Q(W-F).F, fully pipelined.
// Pipeline: 3 front stages, a square-root chain of COEF_WIDTH+1 cells, a numerator stage,
// a divider chain of COEF_WIDTH+FRAC_BITS+3 cells and the output register.
// Throughput one item per cycle. The whole pipeline advances together; it holds
// while a result waits on out_tready.
// Synchronous active-low reset clears the valid bits only.
module quadratic_real_root_solver import qrrs_pkg::*; #(
  parameter int COEF_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // coef_square, coef_linear, coef_constant, zero pad
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // root_first, root_second, zero pad
  output logic [((2*COEF_WIDTH+7)/8)*8-1:0] out_tdata,
  // status[1:0], saturated[2]
  output logic [2:0] out_tuser
);

  localparam int W      = COEF_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int DW     = 2 * W + 2;      // discriminant width
  localparam int SW     = W + 1;          // square root width, one cell per bit
  localparam int NM_W   = W + 2;          // |-b +/- sqrt(D)|
  localparam int NUM_W  = W + F + 3;      // scaled numerator, one divider cell per bit
  localparam int DIV_W  = W + 1;          // 2|a|
  localparam int SQ_SIDE = 2 * W + 4;     // status, sign a, sign b, |a|, |b|
  localparam int DV_SIDE = 4;             // status, lane negate flags
  localparam int OUT_TW = ((2*W+7)/8)*8;

  // whole pipeline steps when the output register is free or being drained
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- front end ----------------
  logic          f_valid, f_sa, f_sb;
  logic [DW-1:0] f_d;
  status_t       f_st;
  logic [W-1:0]  f_am, f_bm;

  qrrs_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_i  (in_tvalid),
    .coef_a_i (in_tdata[W-1:0]),
    .coef_b_i (in_tdata[2*W-1:W]),
    .coef_c_i (in_tdata[3*W-1:2*W]),
    .valid_o  (f_valid),
    .d_o      (f_d),
    .status_o (f_st),
    .sa_o     (f_sa),
    .sb_o     (f_sb),
    .am_o     (f_am),
    .bm_o     (f_bm)
  );

  // ---------------- square root chain ----------------
  logic               sq_v    [0:SW];
  logic [DW-1:0]      sq_rad  [0:SW];
  logic [SW:0]        sq_rem  [0:SW];
  logic [SW-1:0]      sq_root [0:SW];
  logic [SQ_SIDE-1:0] sq_side [0:SW];

  assign sq_v[0]    = f_valid;
  assign sq_rad[0]  = f_d;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {f_st, f_sa, f_sb, f_am, f_bm};

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrrs_sqrt_cell #(.RAD_W(DW), .ROOT_W(SW), .SIDE_W(SQ_SIDE)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (sq_v[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .side_i  (sq_side[i]),
      .valid_o (sq_v[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // ---------------- numerator stage ----------------
  status_t             s_st;
  logic                s_sa, s_sb;
  logic [W-1:0]        s_am, s_bm;
  logic signed [W+2:0] nb, s_e, n_a, n_b;
  logic [W+2:0]        mag_a, mag_b;
  status_t             n_st_nxt;

  assign s_st = status_t'(sq_side[SW][SQ_SIDE-1 -: 2]);
  assign {s_sa, s_sb, s_am, s_bm} = sq_side[SW][SQ_SIDE-3:0];

  always_comb begin
    nb    = s_sb ? signed'({3'b000, s_bm}) : -signed'({3'b000, s_bm});
    s_e   = signed'({2'b00, sq_root[SW]});
    n_a   = nb + s_e;
    n_b   = nb - s_e;
    mag_a = n_a[W+2] ? -n_a : n_a;
    mag_b = n_b[W+2] ? -n_b : n_b;
    // a zero square root can only come from a zero discriminant
    n_st_nxt = s_st;
    if (s_st == ST_TWO && sq_root[SW] == '0) begin
      n_st_nxt = ST_DOUBLE;
    end
  end

  logic               n_v_r;
  logic [NUM_W-1:0]   num_a_r, num_b_r;
  logic [DIV_W-1:0]   dvs_r;
  logic [DV_SIDE-1:0] n_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_v_r <= 1'b0;
    end else if (en) begin
      n_v_r <= sq_v[SW];
    end
  end

  // rounding: (|n|*2^F + |a|) / (2|a|) rounds half away from zero
  always_ff @(posedge clk) begin
    if (en) begin
      num_a_r  <= (NUM_W'(mag_a[NM_W-1:0]) << F) + NUM_W'(s_am);
      num_b_r  <= (NUM_W'(mag_b[NM_W-1:0]) << F) + NUM_W'(s_am);
      dvs_r    <= {s_am, 1'b0};
      n_side_r <= {n_st_nxt, n_a[W+2] ^ s_sa, n_b[W+2] ^ s_sa};
    end
  end

  // ---------------- divider chain ----------------
  logic               dv_v    [0:NUM_W];
  logic [DIV_W-1:0]   dv_div  [0:NUM_W];
  logic [NUM_W-1:0]   dv_na   [0:NUM_W];
  logic [NUM_W-1:0]   dv_nb   [0:NUM_W];
  logic [DIV_W-1:0]   dv_ra   [0:NUM_W];
  logic [DIV_W-1:0]   dv_rb   [0:NUM_W];
  logic [NUM_W-1:0]   dv_qa   [0:NUM_W];
  logic [NUM_W-1:0]   dv_qb   [0:NUM_W];
  logic [DV_SIDE-1:0] dv_side [0:NUM_W];

  assign dv_v[0]    = n_v_r;
  assign dv_div[0]  = dvs_r;
  assign dv_na[0]   = num_a_r;
  assign dv_nb[0]   = num_b_r;
  assign dv_ra[0]   = '0;
  assign dv_rb[0]   = '0;
  assign dv_qa[0]   = '0;
  assign dv_qb[0]   = '0;
  assign dv_side[0] = n_side_r;

  for (genvar j = 0; j < NUM_W; j++) begin : g_div
    qrrs_div_cell #(.NUM_W(NUM_W), .DIV_W(DIV_W), .SIDE_W(DV_SIDE)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_i  (dv_v[j]),
      .div_i    (dv_div[j]),
      .num_a_i  (dv_na[j]),
      .num_b_i  (dv_nb[j]),
      .rem_a_i  (dv_ra[j]),
      .rem_b_i  (dv_rb[j]),
      .quot_a_i (dv_qa[j]),
      .quot_b_i (dv_qb[j]),
      .side_i   (dv_side[j]),
      .valid_o  (dv_v[j+1]),
      .div_o    (dv_div[j+1]),
      .num_a_o  (dv_na[j+1]),
      .num_b_o  (dv_nb[j+1]),
      .rem_a_o  (dv_ra[j+1]),
      .rem_b_o  (dv_rb[j+1]),
      .quot_a_o (dv_qa[j+1]),
      .quot_b_o (dv_qb[j+1]),
      .side_o   (dv_side[j+1])
    );
  end

  // ---------------- clip, sign and output register ----------------
  // returns {clipped, value}
  function automatic logic [W:0] clip(input logic [NUM_W-1:0] q, input logic neg);
    logic [NUM_W-1:0] lim;
    logic [W-1:0]     m;
    logic             sat;
    lim = NUM_W'({1'b0, {(W-1){1'b1}}}) + NUM_W'(neg);
    sat = (q > lim);
    m   = sat ? lim[W-1:0] : q[W-1:0];
    return {sat, neg ? (~m + 1'b1) : m};
  endfunction

  status_t    d_st;
  logic       neg_a, neg_b;
  logic [W:0] ca, cb;
  logic       use_a, use_b;

  always_comb begin
    d_st           = status_t'(dv_side[NUM_W][DV_SIDE-1 -: 2]);
    {neg_a, neg_b} = dv_side[NUM_W][1:0];
    ca    = clip(dv_qa[NUM_W], neg_a);
    cb    = clip(dv_qb[NUM_W], neg_b);
    use_a = (d_st == ST_TWO) || (d_st == ST_DOUBLE);
    use_b = (d_st == ST_TWO);
  end

  logic         out_v_r;
  logic [W-1:0] root_a_r, root_b_r;
  status_t      st_r;
  logic         sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_v[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_a_r <= use_a ? ca[W-1:0] : '0;
      root_b_r <= use_b ? cb[W-1:0] : '0;
      st_r     <= d_st;
      sat_r    <= (use_a && ca[W]) || (use_b && cb[W]);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TW'({root_b_r, root_a_r});
  assign out_tuser  = {sat_r, st_r};

  // ---------------- checks ----------------
  a_azero_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st_r == ST_AZERO) |-> (root_a_r == '0) && (root_b_r == '0) && !sat_r)
    else $error("degenerate result carries roots");

  a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st_r == ST_NONE) |-> (root_a_r == '0) && (root_b_r == '0) && !sat_r)
    else $error("no-root result carries roots");

  a_double_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st_r == ST_DOUBLE) |-> (root_b_r == '0))
    else $error("double root result has second root");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(root_a_r) && $stable(st_r) && $stable(sat_r))
    else $error("pipeline moved while output stalled");

endmodule
